FILE: src/assert_macros.svh
// Assertion helpers for the RTL; included by job_queue_with_promote_sort.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Plain condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

FILE: src/jqs_pkg.sv
`default_nettype none
package jqs_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam int IN_W          = 88;
  localparam int REQ_W         = 3;
  localparam int STATUS_W      = 3;
  localparam int POS_W         = 5;
  localparam int WIDE_W        = 9;

  // One job record; the id sits in the lowest bits.
  typedef struct packed {
    logic [15:0] mem;
    logic [15:0] cpu;
    logic [3:0]  typ;
    logic [3:0]  pri;
    logic [15:0] id;
  } entry_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_SORT_L,
    CELL_SORT_R
  } cell_op_t;

  localparam logic [2:0] REQ_ENQ     = 3'd0;
  localparam logic [2:0] REQ_DEQ     = 3'd1;
  localparam logic [2:0] REQ_MODIFY  = 3'd2;
  localparam logic [2:0] REQ_CHANGE  = 3'd3;
  localparam logic [2:0] REQ_PROMOTE = 3'd4;
  localparam logic [2:0] REQ_REORDER = 3'd5;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_BADFIELD = 3'd5;

  localparam logic [2:0] FLD_PRI = 3'd1;
  localparam logic [2:0] FLD_TYP = 3'd2;
  localparam logic [2:0] FLD_CPU = 3'd3;
  localparam logic [2:0] FLD_MEM = 3'd4;

  localparam logic [2:0] KEY_ID  = 3'd1;
  localparam logic [2:0] KEY_PRI = 3'd2;
  localparam logic [2:0] KEY_CPU = 3'd3;

  function automatic logic [15:0] key_of(input entry_t e, input logic [2:0] key);
    logic [15:0] k;
    if (key == KEY_ID) begin
      k = e.id;
    end else if (key == KEY_PRI) begin
      k = {12'd0, e.pri};
    end else begin
      k = e.cpu;
    end
    return k;
  endfunction

endpackage
`default_nettype wire

FILE: src/jqs_cell.sv
`default_nettype none
// One queue slot. Sort pairs: left cell keeps the smaller key, right the larger.
module jqs_cell (
  input  wire                   clk,
  input  wire jqs_pkg::cell_op_t op,
  input  wire  [2:0]            key,
  input  wire jqs_pkg::entry_t  left,
  input  wire jqs_pkg::entry_t  right,
  input  wire jqs_pkg::entry_t  load,
  output jqs_pkg::entry_t       q
);

  logic            gt_right;
  logic            gt_left;
  jqs_pkg::entry_t q_next;

  assign gt_right = jqs_pkg::key_of(q, key) > jqs_pkg::key_of(right, key);
  assign gt_left  = jqs_pkg::key_of(left, key) > jqs_pkg::key_of(q, key);

  always_comb begin
    case (op)
      jqs_pkg::CELL_LOAD:       q_next = load;
      jqs_pkg::CELL_FROM_LEFT:  q_next = left;
      jqs_pkg::CELL_FROM_RIGHT: q_next = right;
      jqs_pkg::CELL_SORT_L:     q_next = gt_right ? right : q;
      jqs_pkg::CELL_SORT_R:     q_next = gt_left ? left : q;
      default:                  q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule
`default_nettype wire

FILE: src/job_queue_with_promote_sort.sv
`default_nettype none
// Channel  | Direction | Signals                 | Word
// ---------+-----------+-------------------------+-------------------------------
// request  | in        | s_tvalid/s_tready/data  | one queue request
// response | out       | m_tvalid/m_tready/data  | status, entry and entry count
//
// After the edge that accepts a request, the compare state (S_FIND) checks its
// id in every cell at once and registers the lookup, and the update state
// (S_EXEC) then applies the change and registers the response. A new request
// is taken only once the block is back in S_IDLE. Reorder with a valid key runs
// odd-even neighbor exchanges in the cell row (S_SORT) before the next request
// is taken. Reset (rst, synchronous) clears the entry count and the handshakes;
// the cell contents are left as they are. A response that is not taken stalls
// the update cycle of the following request only.
`include "assert_macros.svh"
module job_queue_with_promote_sort #(
  parameter int QUEUE_DEPTH = jqs_pkg::DEFAULT_DEPTH,
  localparam int IW    = $clog2(QUEUE_DEPTH),
  localparam int CW    = $clog2(QUEUE_DEPTH + 1),
  localparam int OUT_W = ((56 + CW + 7) / 8) * 8
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     s_tvalid,
  output logic                    s_tready,
  // job id, priority, job kind, cpu time, memory, field select,
  // change value, positions, sort key (lowest bits first), zero padded
  input  wire  [jqs_pkg::IN_W-1:0] s_tdata,
  // req_type
  input  wire  [jqs_pkg::REQ_W-1:0] s_tuser,
  output logic                    m_tvalid,
  input  wire                     m_tready,
  // out_job_id, out_priority, out_job_type, out_cpu_time, out_memory,
  // queue_count (lowest bits first), zero padded
  output logic [OUT_W-1:0]        m_tdata,
  // status
  output logic [jqs_pkg::STATUS_W-1:0] m_tuser
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_EXEC,
    S_SORT
  } state_t;

  state_t state;

  // Latched request.
  logic [2:0]               req;
  jqs_pkg::entry_t          req_rec;
  logic [2:0]               fsel;
  logic [15:0]              nval;
  logic [jqs_pkg::POS_W-1:0] pos;
  logic [2:0]               key;

  logic [CW-1:0]            count;
  logic [IW-1:0]            sort_cnt;

  // Lookup results, registered after the compare cycle.
  logic                     found;
  logic [IW-1:0]            idx;
  jqs_pkg::entry_t          sel;

  logic                     found_next;
  logic [IW-1:0]            idx_next;
  jqs_pkg::entry_t          sel_next;

  jqs_pkg::entry_t          out_rec;
  logic [2:0]               out_status;
  logic [CW-1:0]            out_count;

  jqs_pkg::entry_t          cell_q   [QUEUE_DEPTH];
  jqs_pkg::cell_op_t        cell_op  [QUEUE_DEPTH];
  jqs_pkg::entry_t          load_bus;

  logic                     exec_go;
  logic [2:0]               status_next;
  jqs_pkg::entry_t          rec_next;
  jqs_pkg::entry_t          upd;
  logic [jqs_pkg::WIDE_W-1:0] from_w;
  logic [jqs_pkg::WIDE_W-1:0] to_w;
  logic [QUEUE_DEPTH-1:0]   pair_l;

  assign s_tready = (state == S_IDLE);
  assign exec_go  = (state == S_EXEC) && (!m_tvalid || m_tready);
  assign m_tdata  = OUT_W'({out_count, out_rec});
  assign m_tuser  = out_status;

  // Every cell compares its id at once; ids are unique, so the hits are too.
  always_comb begin
    found_next = 1'b0;
    idx_next   = '0;
    sel_next   = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cell_q[i].id == req_rec.id && CW'(i) < count) begin
        found_next = 1'b1;
        idx_next   = idx_next | IW'(i);
        sel_next   = sel_next | cell_q[i];
      end
    end
  end

  // The change request rewrites one field of the found entry.
  always_comb begin
    upd = sel;
    case (fsel)
      jqs_pkg::FLD_PRI: upd.pri = nval[3:0];
      jqs_pkg::FLD_TYP: upd.typ = nval[3:0];
      jqs_pkg::FLD_CPU: upd.cpu = nval;
      jqs_pkg::FLD_MEM: upd.mem = nval;
      default:          upd = sel;
    endcase
  end

  // Promote target, clamped at the head.
  assign from_w = jqs_pkg::WIDE_W'(idx);
  assign to_w   = (jqs_pkg::WIDE_W'(pos) >= from_w) ? '0
                  : from_w - jqs_pkg::WIDE_W'(pos);

  // Status and response record for the update cycle.
  always_comb begin
    status_next = jqs_pkg::ST_OK;
    rec_next    = '0;
    load_bus    = req_rec;
    case (req)
      jqs_pkg::REQ_ENQ: begin
        if (found) begin
          status_next = jqs_pkg::ST_DUP;
        end else if (count == CW'(QUEUE_DEPTH)) begin
          status_next = jqs_pkg::ST_FULL;
        end else begin
          rec_next = req_rec;
        end
      end
      jqs_pkg::REQ_DEQ: begin
        if (count == '0) begin
          status_next = jqs_pkg::ST_EMPTY;
        end else begin
          rec_next = cell_q[0];
        end
      end
      jqs_pkg::REQ_MODIFY: begin
        if (!found) begin
          status_next = jqs_pkg::ST_NOTFOUND;
        end else begin
          rec_next = req_rec;
        end
      end
      jqs_pkg::REQ_CHANGE: begin
        load_bus = upd;
        if (!found) begin
          status_next = jqs_pkg::ST_NOTFOUND;
        end else if (fsel != jqs_pkg::FLD_PRI && fsel != jqs_pkg::FLD_TYP &&
                     fsel != jqs_pkg::FLD_CPU && fsel != jqs_pkg::FLD_MEM) begin
          status_next = jqs_pkg::ST_BADFIELD;
        end else begin
          rec_next = upd;
        end
      end
      jqs_pkg::REQ_PROMOTE: begin
        load_bus = sel;
        if (!found) begin
          status_next = jqs_pkg::ST_NOTFOUND;
        end else begin
          rec_next = sel;
        end
      end
      default: begin
        status_next = jqs_pkg::ST_OK;
      end
    endcase
  end

  // Pair (i, i+1) exchanges in this sort step when i matches the phase and
  // both slots hold live entries.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      pair_l[i] = (i < QUEUE_DEPTH - 1) && (1'(i) == sort_cnt[0]) &&
                  (CW'(i + 1) < count);
    end
  end

  // Per-cell command.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_op[i] = jqs_pkg::CELL_HOLD;
      if (state == S_SORT) begin
        if (pair_l[i]) begin
          cell_op[i] = jqs_pkg::CELL_SORT_L;
        end else if (i > 0 && pair_l[(i > 0) ? i - 1 : 0]) begin
          cell_op[i] = jqs_pkg::CELL_SORT_R;
        end
      end else if (exec_go && status_next == jqs_pkg::ST_OK) begin
        case (req)
          jqs_pkg::REQ_ENQ: begin
            if (CW'(i) == count) cell_op[i] = jqs_pkg::CELL_LOAD;
          end
          jqs_pkg::REQ_DEQ: begin
            cell_op[i] = jqs_pkg::CELL_FROM_RIGHT;
          end
          jqs_pkg::REQ_MODIFY, jqs_pkg::REQ_CHANGE: begin
            if (IW'(i) == idx) cell_op[i] = jqs_pkg::CELL_LOAD;
          end
          jqs_pkg::REQ_PROMOTE: begin
            if (jqs_pkg::WIDE_W'(i) == to_w) begin
              cell_op[i] = jqs_pkg::CELL_LOAD;
            end else if (jqs_pkg::WIDE_W'(i) > to_w &&
                         jqs_pkg::WIDE_W'(i) <= from_w) begin
              cell_op[i] = jqs_pkg::CELL_FROM_LEFT;
            end
          end
          default: begin
            cell_op[i] = jqs_pkg::CELL_HOLD;
          end
        endcase
      end
    end
  end

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    jqs_pkg::entry_t left_in;
    jqs_pkg::entry_t right_in;
    if (g == 0) begin : g_head
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_q[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_q[g+1];
    end
    jqs_cell u_cell (
      .clk   (clk),
      .op    (cell_op[g]),
      .key   (key),
      .left  (left_in),
      .right (right_in),
      .load  (load_bus),
      .q     (cell_q[g])
    );
  end

  // Lookup and request registers carry no reset.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req     <= s_tuser;
      req_rec <= jqs_pkg::entry_t'(s_tdata[55:0]);
      fsel    <= s_tdata[58:56];
      nval    <= s_tdata[74:59];
      pos     <= s_tdata[79:75];
      key     <= s_tdata[82:80];
    end
    if (state == S_FIND) begin
      found <= found_next;
      idx   <= idx_next;
      sel   <= sel_next;
    end
    if (exec_go) begin
      out_rec    <= rec_next;
      out_status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      sort_cnt  <= '0;
      m_tvalid  <= 1'b0;
      out_count <= '0;
    end else begin
      // A new response replaces the one taken in the same cycle.
      if (m_tvalid && m_tready && !exec_go) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) state <= S_FIND;
        end
        S_FIND: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (exec_go) begin
            m_tvalid <= 1'b1;
            if (status_next == jqs_pkg::ST_OK && req == jqs_pkg::REQ_ENQ) begin
              count     <= count + CW'(1);
              out_count <= count + CW'(1);
            end else if (status_next == jqs_pkg::ST_OK && req == jqs_pkg::REQ_DEQ) begin
              count     <= count - CW'(1);
              out_count <= count - CW'(1);
            end else begin
              out_count <= count;
            end
            sort_cnt <= '0;
            if (req == jqs_pkg::REQ_REORDER &&
                (key == jqs_pkg::KEY_ID || key == jqs_pkg::KEY_PRI ||
                 key == jqs_pkg::KEY_CPU)) begin
              state <= S_SORT;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_SORT: begin
          sort_cnt <= sort_cnt + IW'(1);
          if (sort_cnt == IW'(QUEUE_DEPTH - 1)) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_count_range, clk, rst, count <= CW'(QUEUE_DEPTH), "entry count overflow")
  `ASSERT_CLK(a_sort_keeps_count, clk, rst, (state == S_SORT) |=> (count == $past(count)), "count moved during sort")
  `ASSERT_CLK(a_resp_from_exec, clk, rst, $rose(m_tvalid) |-> $past(state == S_EXEC), "response without update cycle")
  `ASSERT_CLK(a_count_step, clk, rst, (state != S_EXEC) |=> (count == $past(count)), "count changed outside update")

endmodule
`default_nettype wire

FILE: dv/job_queue_with_promote_sort_test.sv
`default_nettype none
module job_queue_with_promote_sort_test;

  localparam int DEPTH      = jqs_pkg::DEFAULT_DEPTH;
  localparam int OUT_W      = 64;
  localparam int N_RANDOM   = 1400;
  localparam int IDLE_LIMIT = 4000;

  // Requests 6 and 7 are not defined by the block and must change nothing.
  localparam logic [2:0] REQ_UNKNOWN_A = 3'd6;
  localparam logic [2:0] REQ_UNKNOWN_B = 3'd7;

  typedef struct {
    logic [2:0]      status;
    jqs_pkg::entry_t rec;
    logic [4:0]      count;
  } response_t;

  // The scoreboard keeps its own copy of the queue and works out the
  // response of every accepted request word, then checks the returned words
  // against those responses in order.
  class job_queue_scoreboard;
    jqs_pkg::entry_t rows[DEPTH];
    int        used;
    response_t expected_responses[$];
    int        mismatches;

    function void note_request(logic [2:0] req, jqs_pkg::entry_t arg, logic [2:0] fsel,
                               logic [15:0] nval, logic [4:0] pos, logic [2:0] key);
      response_t r;
      int        at;
      int        to;
      jqs_pkg::entry_t hold;
      logic [15:0] ka;
      logic [15:0] kb;
      int        j;
      r.status = jqs_pkg::ST_OK;
      r.rec    = '0;
      at = -1;
      for (int i = 0; i < used; i++) begin
        if (at < 0 && rows[i].id == arg.id) at = i;
      end
      case (req)
        jqs_pkg::REQ_ENQ: begin
          if (at >= 0) r.status = jqs_pkg::ST_DUP;
          else if (used >= DEPTH) r.status = jqs_pkg::ST_FULL;
          else begin
            rows[used] = arg;
            used++;
            r.rec = arg;
          end
        end
        jqs_pkg::REQ_DEQ: begin
          if (used == 0) r.status = jqs_pkg::ST_EMPTY;
          else begin
            r.rec = rows[0];
            for (int i = 0; i + 1 < used; i++) rows[i] = rows[i+1];
            used--;
          end
        end
        jqs_pkg::REQ_MODIFY: begin
          if (at < 0) r.status = jqs_pkg::ST_NOTFOUND;
          else begin
            rows[at].pri = arg.pri;
            rows[at].typ = arg.typ;
            rows[at].cpu = arg.cpu;
            rows[at].mem = arg.mem;
            r.rec = rows[at];
          end
        end
        jqs_pkg::REQ_CHANGE: begin
          if (at < 0) r.status = jqs_pkg::ST_NOTFOUND;
          else begin
            case (fsel)
              jqs_pkg::FLD_PRI: rows[at].pri = nval[3:0];
              jqs_pkg::FLD_TYP: rows[at].typ = nval[3:0];
              jqs_pkg::FLD_CPU: rows[at].cpu = nval;
              jqs_pkg::FLD_MEM: rows[at].mem = nval;
              default: r.status = jqs_pkg::ST_BADFIELD;
            endcase
            if (r.status == jqs_pkg::ST_OK) r.rec = rows[at];
          end
        end
        jqs_pkg::REQ_PROMOTE: begin
          if (at < 0) r.status = jqs_pkg::ST_NOTFOUND;
          else begin
            // A move past the head stops at the head.
            to = (int'(pos) >= at) ? 0 : at - int'(pos);
            hold = rows[at];
            for (int i = at; i > to; i--) rows[i] = rows[i-1];
            rows[to] = hold;
            r.rec = hold;
          end
        end
        jqs_pkg::REQ_REORDER: begin
          // Stable insertion sort; any other key keeps the order as it is.
          if (key == jqs_pkg::KEY_ID || key == jqs_pkg::KEY_PRI ||
              key == jqs_pkg::KEY_CPU) begin
            for (int i = 1; i < used; i++) begin
              hold = rows[i];
              j = i;
              while (j > 0) begin
                ka = (key == jqs_pkg::KEY_ID) ? rows[j-1].id :
                     (key == jqs_pkg::KEY_PRI) ? {12'd0, rows[j-1].pri} : rows[j-1].cpu;
                kb = (key == jqs_pkg::KEY_ID) ? hold.id :
                     (key == jqs_pkg::KEY_PRI) ? {12'd0, hold.pri} : hold.cpu;
                if (ka <= kb) break;
                rows[j] = rows[j-1];
                j--;
              end
              rows[j] = hold;
            end
          end
        end
        default: ;
      endcase
      r.count = used[4:0];
      expected_responses.push_back(r);
    endfunction

    function void check_response(logic [2:0] status, logic [OUT_W-1:0] data);
      response_t       e;
      jqs_pkg::entry_t got;
      bit              bad;
      if (expected_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("response word with nothing expected: status %0d data %h",
                   status, data);
        return;
      end
      e   = expected_responses.pop_front();
      got = data[55:0];
      bad = (status !== e.status) || (got.id !== e.rec.id) || (got.pri !== e.rec.pri) ||
            (got.typ !== e.rec.typ) || (got.cpu !== e.rec.cpu) ||
            (got.mem !== e.rec.mem) || (data[60:56] !== e.count);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected st %0d id %h pri %0d typ %0d cpu %h mem %h",
                    " cnt %0d, got st %0d id %h pri %0d typ %0d cpu %h mem %h cnt %0d"},
                   e.status, e.rec.id, e.rec.pri, e.rec.typ, e.rec.cpu, e.rec.mem,
                   e.count, status, got.id, got.pri, got.typ, got.cpu, got.mem,
                   data[60:56]);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  wire                 s_tready;
  // job id, priority, job kind, cpu time, memory, field select,
  // change value, positions, sort key (lowest bits first), zero padded
  logic [jqs_pkg::IN_W-1:0]     s_tdata = '0;
  // req_type
  logic [jqs_pkg::REQ_W-1:0]    s_tuser = '0;
  wire                 m_tvalid;
  logic                m_tready = 1'b0;
  // out_job_id, out_priority, out_job_type, out_cpu_time, out_memory,
  // queue_count (lowest bits first), zero padded
  wire  [OUT_W-1:0]    m_tdata;
  // status
  wire  [jqs_pkg::STATUS_W-1:0] m_tuser;

  job_queue_with_promote_sort #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  job_queue_scoreboard sb = new();
  int  idle_cycles = 0;
  int  burst_left = 0;
  logic [15:0] id_mask = 16'h0000;

  initial begin
    forever #5 clk = ~clk;
  end

  // The receiver alternates between long always-ready stretches and
  // stretches of random stalls, so backpressure lands on every phase.
  int ready_phase = 0;
  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check_response(m_tuser, m_tdata);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    ready_phase <= (ready_phase + 1) % 300;
    if (ready_phase < 100) m_tready <= 1'b1;
    else if (ready_phase < 200) m_tready <= ($urandom_range(0, 3) != 0);
    else m_tready <= ($urandom_range(0, 2) == 0);
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Present one request word and hold it until the block takes it. After
  // that the sender either goes straight on or idles for a random gap.
  task automatic send_request(logic [2:0] req, jqs_pkg::entry_t arg, logic [2:0] fsel,
                              logic [15:0] nval, logic [4:0] pos, logic [2:0] key);
    int gap;
    s_tuser  <= req;
    s_tdata  <= {5'd0, key, pos, nval, fsel, arg.mem, arg.cpu, arg.typ, arg.pri, arg.id};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_request(req, arg, fsel, nval, pos, key);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic jqs_pkg::entry_t make_job(logic [15:0] id);
    jqs_pkg::entry_t e;
    e.id  = id;
    e.pri = 4'($urandom_range(1, 10));
    e.typ = 4'($urandom_range(1, 10));
    e.cpu = 16'($urandom);
    e.mem = 16'($urandom);
    return e;
  endfunction

  task automatic send_simple(logic [2:0] req, logic [15:0] id);
    send_request(req, make_job(id), 3'($urandom_range(0, 7)), 16'($urandom),
                 5'($urandom_range(0, 16)), 3'($urandom_range(0, 7)));
  endtask

  initial begin
    logic [2:0]      req;
    int              pick;
    jqs_pkg::entry_t job;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty queue, extreme ids and fields, duplicates, every
    // change selector, promote with zero and clamped moves, every sort key
    // and the two undefined requests.
    send_simple(jqs_pkg::REQ_DEQ, 16'h0000);
    send_simple(jqs_pkg::REQ_MODIFY, 16'h1234);
    send_request(jqs_pkg::REQ_ENQ, '{mem: 16'hFFFF, cpu: 16'hFFFF, typ: 4'd10, pri: 4'd10,
                                     id: 16'hFFFF}, 3'd0, 16'd0, 5'd0, 3'd0);
    send_request(jqs_pkg::REQ_ENQ, '{mem: 16'h0000, cpu: 16'h0000, typ: 4'd1, pri: 4'd1,
                                     id: 16'h0000}, 3'd7, 16'hFFFF, 5'd31, 3'd7);
    send_simple(jqs_pkg::REQ_ENQ, 16'hFFFF);
    send_simple(jqs_pkg::REQ_ENQ, 16'h00A5);
    for (int f = 0; f < 8; f++)
      send_request(jqs_pkg::REQ_CHANGE, make_job(16'h00A5), f[2:0], 16'hFFFF, 5'd0, 3'd0);
    send_simple(jqs_pkg::REQ_CHANGE, 16'h7777);
    send_request(jqs_pkg::REQ_PROMOTE, make_job(16'h00A5), 3'd0, 16'd0, 5'd0, 3'd0);
    send_request(jqs_pkg::REQ_PROMOTE, make_job(16'h00A5), 3'd0, 16'd0, 5'd16, 3'd0);
    send_simple(jqs_pkg::REQ_MODIFY, 16'h0000);
    for (int k = 0; k < 8; k++)
      send_request(jqs_pkg::REQ_REORDER, make_job(16'd0), 3'd0, 16'd0, 5'd0, k[2:0]);
    send_simple(REQ_UNKNOWN_A, 16'h0000);
    send_simple(REQ_UNKNOWN_B, 16'hFFFF);

    // Random part: ids mostly come from a small pool so lookups hit and
    // duplicates occur; the pool's high bits move every hundred words.
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 100 == 0) id_mask = 16'($urandom) & 16'hFFE0;
      pick = $urandom_range(0, 99);
      if (sb.used < 6 && pick < 50) req = jqs_pkg::REQ_ENQ;
      else if (pick < 25) req = jqs_pkg::REQ_ENQ;
      else if (pick < 42) req = jqs_pkg::REQ_DEQ;
      else if (pick < 52) req = jqs_pkg::REQ_MODIFY;
      else if (pick < 67) req = jqs_pkg::REQ_CHANGE;
      else if (pick < 84) req = jqs_pkg::REQ_PROMOTE;
      else if (pick < 96) req = jqs_pkg::REQ_REORDER;
      else req = ($urandom_range(0, 1) != 0) ? REQ_UNKNOWN_A : REQ_UNKNOWN_B;
      job = make_job(($urandom_range(0, 19) == 0) ? 16'($urandom)
                                                  : (id_mask | 16'($urandom_range(0, 23))));
      send_request(req, job, 3'($urandom_range(0, 7)), 16'($urandom),
                   5'($urandom_range(0, 16)), 3'($urandom_range(0, 7)));
    end
    s_tvalid <= 1'b0;

    while (sb.expected_responses.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_responses.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
`default_nettype wire
